// ===== sv/assert_macros.svh =====
// Assertion macros shared by the accumulator ALU RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cau_pkg.sv =====
// Shared types and constants for the chained accumulator ALU.
// No dependencies; imported by cau_ctrl, cau_dp and the top level.
package cau_pkg;

  localparam int DATA_W    = 64;
  localparam int HALF_W    = DATA_W / 2;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Multiply sequence, one 32x32 product per step.
  typedef enum logic [1:0] {
    MUL_LL  = 2'd0,  // lo*lo
    MUL_HL  = 2'd1,  // hi(acc)*lo(b), take lo*lo into the sum
    MUL_LH  = 2'd2,  // lo(acc)*hi(b), add cross term
    MUL_SUM = 2'd3   // add last cross term
  } mul_step_t;

  typedef struct packed {
    logic      load;      // capture input item, set up divider
    logic      mul_en;
    mul_step_t mul_step;
    logic      div_step;  // one restoring divide iteration
    logic      commit;    // write accumulator and output register
  } cmd_t;

  typedef struct packed {
    logic divisor_zero;
  } stat_t;

endpackage

// ===== sv/cau_ctrl.sv =====
// Sequencer for the chained accumulator ALU: item dispatch, multiply and
// divide step counting, output register valid. Uses cau_pkg, assert_macros.svh.
`include "assert_macros.svh"

module cau_ctrl import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  start_req,
  input  logic  [1:0] opcode,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             slot_free;
  logic             in_xfer;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_xfer;
    cmd.mul_step = mul_step_t'(cnt[1:0]);
    case (state)
      S_MUL:    cmd.mul_en   = 1'b1;
      S_DIV:    cmd.div_step = !stat.divisor_zero;
      S_COMMIT: cmd.commit   = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_xfer) begin
            if (start_req) begin
              state <= S_COMMIT;
            end else begin
              case (op_t'(opcode))
                OP_MUL:  state <= S_MUL;
                OP_DIV:  state <= S_DIV;
                default: state <= S_COMMIT;
              endcase
            end
          end
        end
        S_MUL: begin
          cnt <= cnt + CNT_W'(1);
          if (mul_step_t'(cnt[1:0]) == MUL_SUM) begin
            state <= S_COMMIT;
          end
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (stat.divisor_zero || cnt == DIV_LAST) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_commit_slot, cmd.commit |-> (!out_valid || out_ready), "commit into full output")
  `ASSERT_CLK(a_commit_valid, cmd.commit |=> out_valid, "commit did not raise out_valid")
  `ASSERT_CLK(a_one_item, in_xfer |=> !in_ready, "second item taken while busy")
  `ASSERT_ALWAYS(a_rst_idle, rst |=> (in_ready && !out_valid), "reset did not idle block")

endmodule

// ===== sv/cau_dp.sv =====
// Datapath for the chained accumulator ALU: accumulator, shared 32x32
// multiplier, radix-2 restoring divider, output register. Uses cau_pkg.
module cau_dp import cau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              start_req,
  input  logic [1:0]        opcode,
  input  logic [DATA_W-1:0] operand,
  output stat_t             stat,
  output logic [DATA_W-1:0] running_value,
  output logic              divide_by_zero
);

  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   b;
  logic                start_r;
  op_t                 op_r;
  logic [DATA_W-1:0]   den;
  logic [DATA_W-1:0]   quo;
  logic [DATA_W-1:0]   rem;
  logic                neg;
  logic [DATA_W-1:0]   prod;
  logic [DATA_W-1:0]   mul_sum;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [DATA_W-1:0]   rem_shift;
  logic [DATA_W:0]     diff;
  logic [DATA_W-1:0]   result;
  logic                dz;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  assign stat.divisor_zero = (b == '0);

  // operand select for the shared multiplier
  assign mul_a = (cmd.mul_step == MUL_HL) ? acc[DATA_W-1:HALF_W] : acc[HALF_W-1:0];
  assign mul_b = (cmd.mul_step == MUL_LH) ? b[DATA_W-1:HALF_W] : b[HALF_W-1:0];

  // restoring divide: remainder stays below den <= 2^63
  assign rem_shift = {rem[DATA_W-2:0], quo[DATA_W-1]};
  assign diff      = {1'b0, rem_shift} - {1'b0, den};

  always_comb begin
    dz = 1'b0;
    if (start_r) begin
      result = b;
    end else begin
      case (op_r)
        OP_ADD:  result = acc + b;
        OP_SUB:  result = acc - b;
        OP_MUL:  result = mul_sum;
        OP_DIV: begin
          dz     = stat.divisor_zero;
          result = dz ? acc : (neg ? (~quo + DATA_W'(1)) : quo);
        end
        default: result = acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.commit) begin
      acc <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b       <= operand;
      start_r <= start_req;
      op_r    <= op_t'(opcode);
      den     <= mag(operand);
      quo     <= mag(acc);
      rem     <= '0;
      neg     <= acc[DATA_W-1] ^ operand[DATA_W-1];
    end else if (cmd.div_step) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.mul_en) begin
      prod <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
      case (cmd.mul_step)
        MUL_LL:  mul_sum <= '0;
        MUL_HL:  mul_sum <= prod;
        default: mul_sum <= mul_sum + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
    end
    if (cmd.commit) begin
      running_value  <= result;
      divide_by_zero <= dz;
    end
  end

endmodule

// ===== sv/chained_accumulator_alu_unit.sv =====
// Chained accumulator ALU, top level: controller and datapath wiring.
// Uses cau_pkg, cau_ctrl, cau_dp.
//
// A signed 64-bit accumulator evaluated strictly left to right. Each input
// transfer carries start_req, opcode and operand; a start transfer loads the
// operand, any other applies add, subtract, multiply (low 64 bits) or a
// truncating signed divide to the accumulator. Every input transfer yields
// exactly one output transfer: the accumulator afterwards in running_value,
// with divide_by_zero set when a divide saw a zero operand (the accumulator
// is then left as it was). Overflow, including minimum / -1, wraps.
// One item is in flight at a time. Start, add and subtract go from the input
// transfer straight to the commit state; multiply makes four passes through
// a single 32x32 multiplier; divide runs the radix-2 restoring divider,
// producing one quotient bit per cycle, and a divide by zero goes straight
// from the divide state to commit. The output register lets the next item
// be taken while a result waits for out_ready. Reset is synchronous and
// clears the accumulator to zero.

module chained_accumulator_alu_unit import cau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     start_req,
  input  logic [1:0]               opcode,
  input  logic signed [DATA_W-1:0] operand,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] running_value,
  output logic                     divide_by_zero
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: dispatch, multiply/divide step counts, output valid.
  cau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Accumulator, multiplier, divider and result register.
  cau_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .start_req      (start_req),
    .opcode         (opcode),
    .operand        (operand),
    .stat           (stat),
    .running_value  (running_value),
    .divide_by_zero (divide_by_zero)
  );

endmodule
